FILE: rtl/volume_weighted_group_average_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the volume weighted group average block
// Concurrent checks in simulation; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef VOLUME_WEIGHTED_GROUP_AVERAGE_MACROS_SVH
`define VOLUME_WEIGHTED_GROUP_AVERAGE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define VWGA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vwga: same-cycle check failed");

// Next-cycle implication.
`define VWGA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vwga: next-cycle check failed");

`else

`define VWGA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define VWGA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/vwga_pkg.sv
// ----------------------------------------------------------------------------
// vwga_pkg
// Shared constants and types of the volume weighted group average block.
// ----------------------------------------------------------------------------
`default_nettype none

package vwga_pkg;

    localparam int MAX_LEVEL_DEF  = 7;
    localparam int VALUE_BITS_DEF = 24;
    localparam int VOL_W          = 24;
    localparam int LEVEL_W        = 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_START,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    // accumulator controls
    typedef struct packed {
        logic load;   // capture value * volume of the accepted cell
        logic add;    // fold captured product into the run sums
        logic clear;  // zero the run sums
    } acc_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/volume_weighted_group_average.sv
// ----------------------------------------------------------------------------
// volume_weighted_group_average
// Groups cells of a grid line in runs of 2^(L-1), cut short at line end,
// and writes the volume-weighted average of each run back once per cell of the run.
// ----------------------------------------------------------------------------
//
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+----------------------------------
// cell     | in        | cell_valid / cell_stall     | cell_value, cell_volume, level,
//          |           |                            | line_end
// result   | out       | result_valid / result_stall | average, group_last, zero_volume
//
// Sequence: each cell is accepted, then the registered product is
// accumulated. A completed run then passes a start state, the divider
// and an emit state that delivers one result per cell of the run. A
// zero-volume run skips the divider. Level-1 cells go from accept
// straight to emit.
// The shared restoring divider produces one quotient bit per cycle.
// Reset: asynchronous, all control state and run sums cleared; no sweep.
// Stalls: result_stall holds the emit sequence; no new cell is taken until
// the last transaction of a run has been delivered.
// ----------------------------------------------------------------------------
`default_nettype none

`include "volume_weighted_group_average_macros.svh"

module volume_weighted_group_average #(
    parameter int MAX_LEVEL  = vwga_pkg::MAX_LEVEL_DEF,
    parameter int VALUE_BITS = vwga_pkg::VALUE_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // cell channel
    input  wire logic                               cell_valid,
    output logic                                    cell_stall,
    input  wire logic signed [VALUE_BITS-1:0]       cell_value,
    input  wire logic        [vwga_pkg::VOL_W-1:0]  cell_volume,
    input  wire logic        [vwga_pkg::LEVEL_W-1:0] level,
    input  wire logic                               line_end,
    // result channel
    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output logic signed [VALUE_BITS-1:0]            average,
    output logic                                    group_last,
    output logic                                    zero_volume
);
    import vwga_pkg::*;

    localparam int WSUM_W = VALUE_BITS + VOL_W + MAX_LEVEL - 1;
    localparam int VSUM_W = VOL_W + MAX_LEVEL - 1;
    localparam int CNT_W  = MAX_LEVEL;   // holds a full run of 2^(MAX_LEVEL-1)

    state_t state_reg, state_next;

    logic [CNT_W-1:0]         cnt_reg, cnt_next;        // cells in open run
    logic [LEVEL_W-1:0]       lvl_reg, lvl_next;        // level latched at run start
    logic                     last_reg, last_next;      // line_end of newest cell
    logic [CNT_W-1:0]         emit_left_reg, emit_left_next;
    logic signed [VALUE_BITS-1:0] avg_reg, avg_next;
    logic                     zero_reg, zero_next;

    logic                     cell_fire;
    logic                     result_fire;
    logic [LEVEL_W-1:0]       lvl_clamped;
    logic [LEVEL_W-1:0]       eff_lvl;
    logic [CNT_W-1:0]         grp_size;
    logic                     run_done;
    logic                     vsum_zero;

    acc_ctrl_t                acc_ctrl;
    logic signed [WSUM_W-1:0] wsum;
    logic [VSUM_W-1:0]        vsum;
    logic                     div_start;
    logic                     div_done;
    logic signed [VALUE_BITS-1:0] div_quot;

    assign cell_fire   = cell_valid && !cell_stall;
    assign result_fire = result_valid && !result_stall;

    // level zero acts as one; levels above the limit saturate
    always_comb
    begin
        if (level == '0)
            lvl_clamped = LEVEL_W'(1);
        else if (level > LEVEL_W'(MAX_LEVEL))
            lvl_clamped = LEVEL_W'(MAX_LEVEL);
        else
            lvl_clamped = level;
    end

    // later cells of a run keep the level of its first cell
    assign eff_lvl   = (cnt_reg == '0) ? lvl_clamped : lvl_reg;
    assign grp_size  = CNT_W'(1) << (lvl_reg - LEVEL_W'(1));
    assign run_done  = (cnt_reg == grp_size) || last_reg;
    assign vsum_zero = (vsum == '0);

    // ---- sequencer: next state ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cell_fire)
                    state_next = (eff_lvl == LEVEL_W'(1)) ? ST_EMIT : ST_ACCUM;
            end
            ST_ACCUM:
                state_next = run_done ? ST_START : ST_IDLE;
            ST_START:
                state_next = vsum_zero ? ST_EMIT : ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (div_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (result_fire && emit_left_reg == CNT_W'(1))
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ---- sequencer: outputs ----
    always_comb
    begin
        cell_stall     = 1'b1;
        result_valid   = 1'b0;
        acc_ctrl       = '0;
        div_start      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // input is open here, so valid alone means a transaction
                cell_stall    = 1'b0;
                acc_ctrl.load = cell_valid;
            end
            ST_ACCUM:
                acc_ctrl.add = 1'b1;
            ST_START:
            begin
                div_start      = !vsum_zero;
                acc_ctrl.clear = vsum_zero;
            end
            ST_DIVIDE:
                acc_ctrl.clear = div_done;
            ST_EMIT:
                result_valid = 1'b1;
            default:
                cell_stall = 1'b1;
        endcase
    end

    // ---- run bookkeeping and result register ----
    always_comb
    begin
        cnt_next       = cnt_reg;
        lvl_next       = lvl_reg;
        last_next      = last_reg;
        emit_left_next = emit_left_reg;
        avg_next       = avg_reg;
        zero_next      = zero_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cell_fire)
                begin
                    lvl_next  = eff_lvl;
                    last_next = line_end;
                    if (eff_lvl == LEVEL_W'(1))
                    begin
                        // pass-through run of one cell
                        avg_next       = cell_value;
                        zero_next      = 1'b0;
                        emit_left_next = CNT_W'(1);
                    end
                    else
                        cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_START:
            begin
                if (vsum_zero)
                begin
                    avg_next       = '0;
                    zero_next      = 1'b1;
                    emit_left_next = cnt_reg;
                    cnt_next       = '0;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    avg_next       = div_quot;
                    zero_next      = 1'b0;
                    emit_left_next = cnt_reg;
                    cnt_next       = '0;
                end
            end
            ST_EMIT:
            begin
                if (result_fire)
                    emit_left_next = emit_left_reg - CNT_W'(1);
            end
            default:
                cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            lvl_reg       <= LEVEL_W'(1);
            last_reg      <= 1'b0;
            emit_left_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            lvl_reg       <= lvl_next;
            last_reg      <= last_next;
            emit_left_reg <= emit_left_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        avg_reg  <= avg_next;
        zero_reg <= zero_next;
    end

    assign average     = avg_reg;
    assign zero_volume = zero_reg;
    assign group_last  = (emit_left_reg == CNT_W'(1));

    // ---- datapath ----
    vwga_accum #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_LEVEL  (MAX_LEVEL)
    ) u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (acc_ctrl),
        .cell_value  (cell_value),
        .cell_volume (cell_volume),
        .wsum        (wsum),
        .vsum        (vsum)
    );

    vwga_div #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_LEVEL  (MAX_LEVEL)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (wsum),
        .divisor  (vsum),
        .done     (div_done),
        .quotient (div_quot)
    );

    // no cell taken while results of a run are pending
    `VWGA_ASSERT_IMPL(a_no_overlap, clk, rst_n, result_valid, cell_stall)
    // the final transaction of a run ends the emit sequence
    `VWGA_ASSERT_NEXT(a_last_ends, clk, rst_n, result_fire && group_last, !result_valid)
    // an open run never grows past its size
    `VWGA_ASSERT_IMPL(a_run_bound, clk, rst_n, cnt_reg != '0, cnt_reg <= grp_size)

endmodule

`default_nettype wire

FILE: rtl/vwga_accum.sv
// ----------------------------------------------------------------------------
// vwga_accum
// Registered multiply of value by volume and the two run accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module vwga_accum #(
    parameter int VALUE_BITS = vwga_pkg::VALUE_BITS_DEF,
    parameter int MAX_LEVEL  = vwga_pkg::MAX_LEVEL_DEF
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire vwga_pkg::acc_ctrl_t                        ctrl,
    input  wire logic signed [VALUE_BITS-1:0]               cell_value,
    input  wire logic        [vwga_pkg::VOL_W-1:0]          cell_volume,
    output logic signed [VALUE_BITS+vwga_pkg::VOL_W+MAX_LEVEL-2:0] wsum,
    output logic        [vwga_pkg::VOL_W+MAX_LEVEL-2:0]     vsum
);
    import vwga_pkg::*;

    localparam int PROD_W = VALUE_BITS + VOL_W;
    localparam int WSUM_W = PROD_W + MAX_LEVEL - 1;
    localparam int VSUM_W = VOL_W + MAX_LEVEL - 1;

    logic signed [PROD_W:0]   prod_full;
    logic signed [PROD_W-1:0] prod_reg;
    logic [VOL_W-1:0]         vol_reg;
    logic signed [WSUM_W-1:0] wsum_reg, wsum_next;
    logic [VSUM_W-1:0]        vsum_reg, vsum_next;

    assign prod_full = cell_value * $signed({1'b0, cell_volume});

    // product stage, payload only
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            prod_reg <= prod_full[PROD_W-1:0];
            vol_reg  <= cell_volume;
        end
    end

    always_comb
    begin
        wsum_next = wsum_reg;
        vsum_next = vsum_reg;
        if (ctrl.clear)
        begin
            wsum_next = '0;
            vsum_next = '0;
        end
        else if (ctrl.add)
        begin
            wsum_next = wsum_reg + WSUM_W'(prod_reg);
            vsum_next = vsum_reg + VSUM_W'(vol_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsum_reg <= '0;
            vsum_reg <= '0;
        end
        else
        begin
            wsum_reg <= wsum_next;
            vsum_reg <= vsum_next;
        end
    end

    assign wsum = wsum_reg;
    assign vsum = vsum_reg;

endmodule

`default_nettype wire

FILE: rtl/vwga_div.sv
// ----------------------------------------------------------------------------
// vwga_div
// Signed by unsigned restoring divider, one quotient bit per cycle,
// truncating toward zero, result clamped to the value range.
// ----------------------------------------------------------------------------
`default_nettype none

`include "volume_weighted_group_average_macros.svh"

module vwga_div #(
    parameter int VALUE_BITS = vwga_pkg::VALUE_BITS_DEF,
    parameter int MAX_LEVEL  = vwga_pkg::MAX_LEVEL_DEF
) (
    input  wire logic                                                  clk,
    input  wire logic                                                  rst_n,
    input  wire logic                                                  start,
    input  wire logic signed [VALUE_BITS+vwga_pkg::VOL_W+MAX_LEVEL-2:0] dividend,
    input  wire logic        [vwga_pkg::VOL_W+MAX_LEVEL-2:0]           divisor,
    output logic                                                       done,
    output logic signed [VALUE_BITS-1:0]                               quotient
);
    import vwga_pkg::*;

    localparam int WSUM_W = VALUE_BITS + VOL_W + MAX_LEVEL - 1;
    localparam int VSUM_W = VOL_W + MAX_LEVEL - 1;
    localparam int STEP_W = $clog2(VALUE_BITS + 1);

    // |dividend| < divisor * 2^VALUE_BITS, so only the low VALUE_BITS
    // quotient bits can be set; the upper dividend bits seed the remainder.
    logic [WSUM_W-1:0]     mag;
    logic [VSUM_W-1:0]     rem_reg, rem_next;
    logic [VALUE_BITS-1:0] dlo_reg, dlo_next;
    logic [VALUE_BITS-1:0] q_reg, q_next;
    logic                  neg_reg, neg_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [VSUM_W:0]       shifted;
    logic [VSUM_W:0]       diff;
    logic                  qbit;

    assign mag     = dividend[WSUM_W-1] ? WSUM_W'(-dividend) : WSUM_W'(dividend);
    assign shifted = {rem_reg, dlo_reg[VALUE_BITS-1]};
    assign diff    = shifted - {1'b0, divisor};
    assign qbit    = (shifted >= {1'b0, divisor});

    always_comb
    begin
        rem_next  = rem_reg;
        dlo_next  = dlo_reg;
        q_next    = q_reg;
        neg_next  = neg_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = mag[WSUM_W-1:VALUE_BITS];
            dlo_next  = mag[VALUE_BITS-1:0];
            q_next    = '0;
            neg_next  = dividend[WSUM_W-1];
            step_next = STEP_W'(VALUE_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = qbit ? diff[VSUM_W-1:0] : shifted[VSUM_W-1:0];
            dlo_next  = dlo_reg << 1;
            q_next    = {q_reg[VALUE_BITS-2:0], qbit};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dlo_reg <= dlo_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
    end

    // negate back; positive overflow saturates
    always_comb
    begin
        if (neg_reg)
            quotient = -$signed(q_reg);
        else if (q_reg[VALUE_BITS-1])
            quotient = {1'b0, {(VALUE_BITS-1){1'b1}}};
        else
            quotient = $signed(q_reg);
    end

    assign done = done_reg;

    `VWGA_ASSERT_IMPL(a_no_restart, clk, rst_n, busy_reg, !start)
    `VWGA_ASSERT_NEXT(a_done_pulse, clk, rst_n, done_reg, !done_reg)
    `VWGA_ASSERT_IMPL(a_rem_bound, clk, rst_n, busy_reg && !start, rem_reg < divisor)

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for volume_weighted_group_average. Cells are sent
// line by line. Each accepted transaction is folded into a run model, and
// each result transaction is compared against the oldest pending average.
// ----------------------------------------------------------------------------
module tb_top;

    // Block configuration, taken from the package defaults.
    localparam int VB      = vwga_pkg::VALUE_BITS_DEF;
    localparam int MAX_LVL = vwga_pkg::MAX_LEVEL_DEF;
    localparam int VOL_W   = vwga_pkg::VOL_W;
    localparam int LEVEL_W = vwga_pkg::LEVEL_W;

    localparam logic signed [VB-1:0] VALUE_MAX  = {1'b0, {(VB-1){1'b1}}};
    localparam logic signed [VB-1:0] VALUE_MIN  = {1'b1, {(VB-1){1'b0}}};
    localparam logic [VOL_W-1:0]     VOLUME_MAX = '1;

    // Receiver hold-off length of the back-pressure test, in cycles.
    localparam int HOLD_CYCLES = 400;

    // One expected result transaction.
    typedef struct {
        logic signed [VB-1:0] average;
        logic                 group_last;
        logic                 zero_volume;
    } run_result_t;

    // ------------------------------------------------------------------------
    // DUT signals. Every input is given a known value from time zero.
    // ------------------------------------------------------------------------
    logic                        clk;
    logic                        rst_n        = 1'b0;
    logic                        cell_valid   = 1'b0;
    logic                        cell_stall;
    logic signed [VB-1:0]        cell_value   = '0;
    logic        [VOL_W-1:0]     cell_volume  = '0;
    logic        [LEVEL_W-1:0]   level        = '0;
    logic                        line_end     = 1'b0;
    logic                        result_valid;
    logic                        result_stall = 1'b0;
    logic signed [VB-1:0]        average;
    logic                        group_last;
    logic                        zero_volume;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    run_result_t pending_averages[$];   // expected results, oldest first
    run_result_t next_average;          // popped by the result monitor
    int          error_count    = 0;
    int          cells_sent     = 0;
    int          send_idle_pct  = 0;    // chance per cycle that the sender idles
    int          recv_stall_pct = 0;    // chance per cycle that the receiver stalls
    logic        receiver_hold  = 1'b0; // long hold-off of the receiver

    // Run model: the open run's sums, cell count and latched level.
    longint      run_weighted_sum = 0;
    longint      run_volume_sum   = 0;
    int          run_cells        = 0;
    int          run_level        = 1;

    volume_weighted_group_average #(
        .MAX_LEVEL  (MAX_LVL),
        .VALUE_BITS (VB)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cell_valid   (cell_valid),
        .cell_stall   (cell_stall),
        .cell_value   (cell_value),
        .cell_volume  (cell_volume),
        .level        (level),
        .line_end     (line_end),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .average      (average),
        .group_last   (group_last),
        .zero_volume  (zero_volume)
    );

    // 10 ns clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop, well past the length of a clean run.
    initial
    begin
        #5_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Run model. Folds one accepted cell into the open run and queues the
    // results that the cell releases: one per cell of a completed run.
    // ------------------------------------------------------------------------
    function automatic void fold_cell_into_run(
        input logic signed [VB-1:0]      value,
        input logic        [VOL_W-1:0]   volume,
        input logic        [LEVEL_W-1:0] lvl,
        input logic                      last
    );
        int          run_size;
        longint      avg;
        logic        no_volume;
        run_result_t r;

        // The level only counts on the first cell of a run; zero means one,
        // and anything past the top level saturates.
        if (run_cells == 0)
        begin
            run_level = int'(lvl);
            if (run_level < 1)
                run_level = 1;
            if (run_level > MAX_LVL)
                run_level = MAX_LVL;
        end
        run_size = 1 << (run_level - 1);

        // Level one passes the cell straight through.
        if (run_size == 1)
        begin
            r.average     = value;
            r.group_last  = 1'b1;
            r.zero_volume = 1'b0;
            pending_averages.push_back(r);
            run_weighted_sum = 0;
            run_volume_sum   = 0;
            run_cells        = 0;
            return;
        end

        run_weighted_sum += longint'(value) * longint'(volume);
        run_volume_sum   += longint'(volume);
        run_cells++;

        if (run_cells < run_size && !last)
            return;

        // Run complete or cut short by the end of the line.
        if (run_volume_sum == 0)
        begin
            no_volume = 1'b1;
            avg       = 0;
        end
        else
        begin
            no_volume = 1'b0;
            avg       = run_weighted_sum / run_volume_sum;   // truncates toward zero
            if (avg > longint'(VALUE_MAX))
                avg = longint'(VALUE_MAX);
            if (avg < longint'(VALUE_MIN))
                avg = longint'(VALUE_MIN);
        end

        for (int k = 0; k < run_cells; k++)
        begin
            r.average     = avg[VB-1:0];
            r.group_last  = (k == run_cells - 1);
            r.zero_volume = no_volume;
            pending_averages.push_back(r);
        end

        run_weighted_sum = 0;
        run_volume_sum   = 0;
        run_cells        = 0;
    endfunction

    // One line per mismatch; printing stops after a hundred, counting does not.
    task automatic report_mismatch(
        input string              what,
        input logic signed [63:0] got,
        input logic signed [63:0] want
    );
        if (error_count < 100)
            $display("tb_top: mismatch at %0t: %s got %0d want %0d",
                     $realtime, what, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: stall is driven on the falling edge, random per cycle, or
    // held high for a whole stretch while receiver_hold is set.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        result_stall = receiver_hold || ($urandom_range(99) < recv_stall_pct);
    end

    // Result monitor: every transaction is checked against the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            if (pending_averages.size() == 0)
                report_mismatch("result with nothing pending, average", average, 0);
            else
            begin
                next_average = pending_averages.pop_front();
                if (average !== next_average.average)
                    report_mismatch("average", average, next_average.average);
                if (group_last !== next_average.group_last)
                    report_mismatch("group_last", group_last, next_average.group_last);
                if (zero_volume !== next_average.zero_volume)
                    report_mismatch("zero_volume", zero_volume, next_average.zero_volume);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender: offers one cell, with random idle cycles ahead of it, and
    // returns once the transaction is accepted. Valid stays high afterwards
    // so back-to-back cells need no extra edge.
    // ------------------------------------------------------------------------
    task automatic send_cell(
        input logic signed [VB-1:0]      value,
        input logic        [VOL_W-1:0]   volume,
        input logic        [LEVEL_W-1:0] lvl,
        input logic                      last
    );
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cell_valid = 1'b0;
            @(negedge clk);
        end
        cell_valid  = 1'b1;
        cell_value  = value;
        cell_volume = volume;
        level       = lvl;
        line_end    = last;
        @(posedge clk);
        while (cell_stall !== 1'b0)
            @(posedge clk);
        fold_cell_into_run(value, volume, lvl, last);
        cells_sent++;
    endtask

    // One grid line of n_cells cells at level lvl, line_end on the last.
    // Values and volumes mix extremes with random content. Cells inside a
    // run now and then carry a stray level, which must be ignored; a run
    // start rarely does too, which regroups the rest of the line.
    task automatic send_line(input int lvl, input int n_cells, input bit all_zero);
        int                   run_size;
        int                   pick;
        logic signed [VB-1:0] v;
        logic [VOL_W-1:0]     w;
        logic [LEVEL_W-1:0]   l;

        run_size = 1 << (lvl - 1);
        for (int i = 0; i < n_cells; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                v = VALUE_MAX;
            else if (pick < 16)
                v = VALUE_MIN;
            else if (pick < 20)
                v = '0;
            else
                v = VB'($urandom);

            pick = $urandom_range(99);
            if (all_zero || pick < 10)
                w = '0;
            else if (pick < 20)
                w = VOLUME_MAX;
            else if (pick < 45)
                w = VOL_W'($urandom_range(0, 255));
            else
                w = VOL_W'($urandom);

            pick = $urandom_range(99);
            if ((i % run_size == 0 && pick < 5) || (i % run_size != 0 && pick < 15))
                l = LEVEL_W'($urandom_range(0, 7));
            else
                l = LEVEL_W'(lvl);

            send_cell(v, w, l, i == n_cells - 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Level one and level zero: cells pass through, value extremes included.
    task automatic test_level_one();
        send_cell(VALUE_MAX, VOLUME_MAX, 3'd1, 1'b0);
        send_cell(VALUE_MIN, '0, 3'd1, 1'b0);
        send_cell(VB'(0), VOL_W'(1), 3'd0, 1'b0);
        send_cell(VB'(-1), VOL_W'(24'h5A5A5A), 3'd1, 1'b1);
    endtask

    // Full runs, zero volume, short runs and the latched level.
    task automatic test_run_special_cases();
        // max and min at full volume: -0.5 truncates to zero
        send_cell(VALUE_MAX, VOLUME_MAX, 3'd2, 1'b0);
        send_cell(VALUE_MIN, VOLUME_MAX, 3'd2, 1'b0);
        // all volumes zero: average forced to 0, flag on every result
        send_cell(VALUE_MAX, '0, 3'd2, 1'b0);
        send_cell(VB'(-5), '0, 3'd2, 1'b0);
        // run of four cut after two by the end of the line
        send_cell(VB'(1000), VOL_W'(3), 3'd3, 1'b0);
        send_cell(VB'(-7000), VOL_W'(1), 3'd3, 1'b1);
        // level from the first cell holds; later levels 1, 7, 0 are ignored
        send_cell(VALUE_MIN, VOLUME_MAX, 3'd3, 1'b0);
        send_cell(VALUE_MAX, VOL_W'(1), 3'd1, 1'b0);
        send_cell(VB'(12345), VOLUME_MAX, 3'd7, 1'b0);
        send_cell(VB'(-1), VOL_W'(24'h800000), 3'd0, 1'b1);
        // single-cell runs cut by the end of the line
        send_cell(VB'(777), VOL_W'(24'h000123), 3'd4, 1'b1);
        send_cell(VB'(555), '0, 3'd2, 1'b1);
    endtask

    // Random lines. Mostly small levels; the largest level is rare, since
    // one such run costs 64 cells.
    task automatic test_random_lines(input int n_items);
        int first;
        int lvl;
        int run_size;
        int n;
        int pick;

        first = cells_sent;
        while (cells_sent - first < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                lvl = 7;
            else if (pick < 12)
                lvl = $urandom_range(5, 6);
            else
                lvl = $urandom_range(1, 4);
            run_size = 1 << (lvl - 1);

            if (run_size == 1)
                n = $urandom_range(1, 6);
            else
            begin
                n = run_size * ((lvl >= 5) ? 1 : $urandom_range(1, 3));
                if ($urandom_range(99) < 40)
                    n = n - $urandom_range(1, run_size - 1);   // short last run
            end
            send_line(lvl, n, $urandom_range(99) < 8);
        end
    endtask

    // Receiver holds off for a long stretch while cells keep coming, so the
    // block fills and must stall its input.
    task automatic test_backpressure();
        fork
            begin
                @(posedge clk);
                receiver_hold = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                receiver_hold = 1'b0;
            end
        join_none
        send_line(2, 24, 1'b0);
        send_line(1, 6, 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        // Reset once, released on a falling edge.
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Sender mostly busy, receiver mostly stalled.
        send_idle_pct  = 14;
        recv_stall_pct = 75;
        test_level_one();
        test_run_special_cases();
        test_random_lines(140);

        // Sender mostly idle, receiver mostly ready.
        send_idle_pct  = 75;
        recv_stall_pct = 14;
        test_random_lines(140);
        test_backpressure();

        // No idling on either side.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_lines(150);

        // Drain, then give the divider time to show any stray result.
        @(negedge clk);
        cell_valid = 1'b0;
        while (pending_averages.size() != 0)
            @(posedge clk);
        repeat (VB + 40) @(posedge clk);

        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/vwga_pkg.sv
rtl/vwga_accum.sv
rtl/vwga_div.sv
rtl/volume_weighted_group_average.sv
tb/sv/tb_top.sv
